>>> hdl/ftt_pkg.sv
// ftt_pkg: shared types and constants for the function trace table
// used by ftt_store and function_trace_table_core; no dependencies
`default_nettype none

package ftt_pkg;

    localparam int DEPTH_DEF = 16;
    localparam int ADDR_W    = 48;
    localparam int OP_W      = 3;
    localparam int NARGS_W   = 4;
    localparam int FD_W      = 5;
    localparam int TOTAL_W   = 5;

    typedef enum logic [OP_W-1:0] {
        OP_ADD     = 3'd0,
        OP_REMOVE  = 3'd1,
        OP_ENABLE  = 3'd2,
        OP_DISABLE = 3'd3,
        OP_BT_ON   = 3'd4,
        OP_BT_OFF  = 3'd5
    } t_op;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_LAST,
        S_UPDATE
    } t_state;

    // write controls from the sequencer to the slot store
    typedef struct packed {
        logic add;
        logic del;
        logic bt_we;
        logic bt_val;
    } t_wr_ctl;

    // registered read data of one slot
    typedef struct packed {
        logic              valid;
        logic [ADDR_W-1:0] addr;
    } t_slot_rd;

endpackage

`default_nettype wire

>>> hdl/function_trace_table_core.sv
// function_trace_table_core: top level, sequencer with one shared address comparator
// scans the slot store one entry per cycle; depends on ftt_pkg and ftt_store
// a transaction is taken in S_IDLE, S_SCAN reads every slot, S_LAST ends the last compare
//   and S_UPDATE loads the result; no scan when the table is not set up or the op code is invalid
// a new transaction is taken only after the result of the last one is loaded;
//   a stalled result holds the sequencer and the input. reset: synchronous active low
`default_nettype none

module function_trace_table_core #(
    parameter int TABLE_DEPTH = ftt_pkg::DEPTH_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_cfg_we,
    input  wire logic                          i_cfg_wdata,
    input  wire logic                          i_in_valid,
    output logic                               o_in_ready,
    input  wire logic [ftt_pkg::OP_W-1:0]      i_op,
    input  wire logic [ftt_pkg::ADDR_W-1:0]    i_func_addr,
    input  wire logic [ftt_pkg::NARGS_W-1:0]   i_num_args,
    input  wire logic [ftt_pkg::FD_W-1:0]      i_trace_fd,
    output logic                               o_out_valid,
    input  wire logic                          i_out_ready,
    output logic                               o_status,
    output logic [ftt_pkg::TOTAL_W-1:0]        o_entry_total
);

    localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CW = $clog2(TABLE_DEPTH + 1);

    ftt_pkg::t_state              r_state, n_state;
    logic                         r_table_ready;
    logic [ftt_pkg::OP_W-1:0]     r_op;
    logic [ftt_pkg::ADDR_W-1:0]   r_addr;
    logic [ftt_pkg::NARGS_W-1:0]  r_nargs;
    logic [ftt_pkg::FD_W-1:0]     r_fd;
    logic [IW-1:0]                r_idx, n_idx;
    logic [IW-1:0]                r_cmp_idx, n_cmp_idx;
    logic                         r_cmp_vld, n_cmp_vld;
    logic                         r_hit_found, n_hit_found;
    logic [IW-1:0]                r_hit_idx, n_hit_idx;
    logic                         r_free_found, n_free_found;
    logic [IW-1:0]                r_free_idx, n_free_idx;
    logic [CW-1:0]                r_count, n_count;
    logic                         r_out_valid;
    logic                         r_status;
    logic [ftt_pkg::TOTAL_W-1:0]  r_total;

    logic                         w_accept;
    logic                         w_op_known;
    logic                         w_res_load;
    logic                         w_err;
    logic                         w_match;
    ftt_pkg::t_slot_rd            w_rd;
    ftt_pkg::t_wr_ctl             w_wr;
    logic [IW-1:0]                w_wr_idx;

    ftt_store #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .IW          (IW)
    ) u_store (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_rd_idx   (r_idx),
        .o_rd       (w_rd),
        .i_wr       (w_wr),
        .i_wr_idx   (w_wr_idx),
        .i_wr_addr  (r_addr),
        .i_wr_nargs (r_nargs),
        .i_wr_fd    (r_fd)
    );

    assign o_in_ready = (r_state == ftt_pkg::S_IDLE);
    assign w_accept   = i_in_valid && o_in_ready;
    assign w_op_known = (i_op <= ftt_pkg::OP_BT_OFF);

    // shared comparator on the registered slot read
    assign w_match = r_cmp_vld && w_rd.valid && (w_rd.addr == r_addr);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_table_ready <= 1'b0;
        end else if (i_cfg_we) begin
            r_table_ready <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_op    <= i_op;
            r_addr  <= i_func_addr;
            r_nargs <= i_num_args;
            r_fd    <= i_trace_fd;
        end
    end

    // outcome of the operation, valid in S_UPDATE
    always_comb begin
        w_err = 1'b1;
        case (r_op)
            ftt_pkg::OP_ADD:     w_err = r_hit_found || !r_free_found;
            ftt_pkg::OP_REMOVE,
            ftt_pkg::OP_ENABLE,
            ftt_pkg::OP_DISABLE,
            ftt_pkg::OP_BT_ON,
            ftt_pkg::OP_BT_OFF:  w_err = !r_hit_found;
            default:             w_err = 1'b1;
        endcase
        if (!r_table_ready) begin
            w_err = 1'b1;
        end
    end

    assign w_res_load = (r_state == ftt_pkg::S_UPDATE) && (!r_out_valid || i_out_ready);

    always_comb begin
        w_wr     = '0;
        w_wr_idx = r_hit_idx;
        n_count  = r_count;
        if (w_res_load && !w_err) begin
            case (r_op)
                ftt_pkg::OP_ADD: begin
                    w_wr.add = 1'b1;
                    w_wr_idx = r_free_idx;
                    n_count  = r_count + 1'b1;
                end
                ftt_pkg::OP_REMOVE: begin
                    w_wr.del = 1'b1;
                    n_count  = r_count - 1'b1;
                end
                ftt_pkg::OP_BT_ON: begin
                    w_wr.bt_we  = 1'b1;
                    w_wr.bt_val = 1'b1;
                end
                ftt_pkg::OP_BT_OFF: begin
                    w_wr.bt_we  = 1'b1;
                    w_wr.bt_val = 1'b0;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ftt_pkg::S_IDLE;
            r_count   <= '0;
            r_cmp_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_count   <= n_count;
            r_cmp_vld <= n_cmp_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx        <= n_idx;
        r_cmp_idx    <= n_cmp_idx;
        r_hit_found  <= n_hit_found;
        r_hit_idx    <= n_hit_idx;
        r_free_found <= n_free_found;
        r_free_idx   <= n_free_idx;
    end

    always_comb begin
        n_state      = r_state;
        n_idx        = r_idx;
        n_cmp_idx    = r_cmp_idx;
        n_cmp_vld    = 1'b0;
        n_hit_found  = r_hit_found;
        n_hit_idx    = r_hit_idx;
        n_free_found = r_free_found;
        n_free_idx   = r_free_idx;

        // first hit and lowest free slot, one slot per cycle
        if (w_match && !r_hit_found) begin
            n_hit_found = 1'b1;
            n_hit_idx   = r_cmp_idx;
        end
        if (r_cmp_vld && !w_rd.valid && !r_free_found) begin
            n_free_found = 1'b1;
            n_free_idx   = r_cmp_idx;
        end

        case (r_state)
            ftt_pkg::S_IDLE: begin
                if (w_accept) begin
                    n_idx        = '0;
                    n_hit_found  = 1'b0;
                    n_free_found = 1'b0;
                    // nothing to look up when the outcome is already an error
                    if (r_table_ready && w_op_known) begin
                        n_state = ftt_pkg::S_SCAN;
                    end else begin
                        n_state = ftt_pkg::S_UPDATE;
                    end
                end
            end
            ftt_pkg::S_SCAN: begin
                n_cmp_vld = 1'b1;
                n_cmp_idx = r_idx;
                if (r_idx == IW'(TABLE_DEPTH - 1)) begin
                    n_state = ftt_pkg::S_LAST;
                end else begin
                    n_idx = r_idx + 1'b1;
                end
            end
            ftt_pkg::S_LAST: begin
                n_state = ftt_pkg::S_UPDATE;
            end
            ftt_pkg::S_UPDATE: begin
                if (w_res_load) begin
                    n_state = ftt_pkg::S_IDLE;
                end
            end
            default: n_state = ftt_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_res_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_res_load) begin
            r_status <= w_err;
            r_total  <= ftt_pkg::TOTAL_W'(n_count);
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_status      = r_status;
    assign o_entry_total = r_total;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(TABLE_DEPTH))
        else $error("entry count above table depth");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> !o_in_ready)
        else $error("input taken again while a transaction is in progress");

    a_remove_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_res_load && !w_err && r_op == ftt_pkg::OP_REMOVE)
        |=> (r_count == $past(r_count) - 1'b1))
        else $error("successful remove did not decrement the entry count");

    a_add_needs_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_wr.add |-> (r_free_found && !r_hit_found && r_count < CW'(TABLE_DEPTH)))
        else $error("add written without a free slot");

endmodule

`default_nettype wire

>>> hdl/ftt_store.sv
// ftt_store: slot storage, valid bits in flops, slot data in small memories
// one registered read port, one write port; depends on ftt_pkg
`default_nettype none

module ftt_store #(
    parameter int TABLE_DEPTH = ftt_pkg::DEPTH_DEF,
    parameter int IW          = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic [IW-1:0]                i_rd_idx,
    output ftt_pkg::t_slot_rd                 o_rd,
    input  wire ftt_pkg::t_wr_ctl             i_wr,
    input  wire logic [IW-1:0]                i_wr_idx,
    input  wire logic [ftt_pkg::ADDR_W-1:0]   i_wr_addr,
    input  wire logic [ftt_pkg::NARGS_W-1:0]  i_wr_nargs,
    input  wire logic [ftt_pkg::FD_W-1:0]     i_wr_fd
);

    logic [TABLE_DEPTH-1:0]        r_valid;
    logic [ftt_pkg::ADDR_W-1:0]    r_addr_mem  [TABLE_DEPTH];
    logic [ftt_pkg::NARGS_W-1:0]   r_nargs_mem [TABLE_DEPTH];
    logic [ftt_pkg::FD_W-1:0]      r_fd_mem    [TABLE_DEPTH];
    logic [TABLE_DEPTH-1:0]        r_bt;
    ftt_pkg::t_slot_rd             r_rd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_wr.add) begin
            r_valid[i_wr_idx] <= 1'b1;
        end else if (i_wr.del) begin
            r_valid[i_wr_idx] <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr.add) begin
            r_addr_mem[i_wr_idx]  <= i_wr_addr;
            r_nargs_mem[i_wr_idx] <= i_wr_nargs;
            r_fd_mem[i_wr_idx]    <= i_wr_fd;
        end
    end

    // new entries start with backtrace off
    always_ff @(posedge i_clk) begin
        if (i_wr.add) begin
            r_bt[i_wr_idx] <= 1'b0;
        end else if (i_wr.bt_we) begin
            r_bt[i_wr_idx] <= i_wr.bt_val;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd.valid <= r_valid[i_rd_idx];
        r_rd.addr  <= r_addr_mem[i_rd_idx];
    end

    assign o_rd = r_rd;

endmodule

`default_nettype wire
